### hdl/scan_code_to_ascii_translator_defines.svh
// ----------------------------------------------------------------------------
// Scan code translator assertion macros
// Shared wrappers for concurrent checks clocked on clk with reset rst.
// ----------------------------------------------------------------------------
`ifndef SCAN_CODE_TO_ASCII_TRANSLATOR_DEFINES_SVH
`define SCAN_CODE_TO_ASCII_TRANSLATOR_DEFINES_SVH

// check outside reset
`define SC2A_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also covers the reset cycles
`define SC2A_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// sc2a_pkg
// Types, scan codes and character maps for the set-1 scan code translator.
// ----------------------------------------------------------------------------
package sc2a_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned MapSize = 89;
  localparam int unsigned MapIdxW = $clog2(MapSize);

  localparam byte_t CodeLShiftMake  = 8'h2A;
  localparam byte_t CodeRShiftMake  = 8'h36;
  localparam byte_t CodeLShiftBreak = 8'hAA;
  localparam byte_t CodeRShiftBreak = 8'hB6;
  localparam byte_t CodeCapsBreak   = 8'hBA;
  localparam byte_t CodeBackspace   = 8'h0E;
  localparam byte_t CodeMapLast     = 8'h58;
  localparam byte_t CharBackspace   = 8'h08;
  localparam byte_t CharNone        = 8'h00;

  typedef struct packed {
    logic lshift;
    logic rshift;
    logic caps;
  } mods_t;

  localparam byte_t LowerMap [MapSize] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85,
    8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D,
    8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
    8'h96, 8'h97, 8'h98, 8'h99, 8'h00, 8'h00, 8'h00, 8'h9A,
    8'h9B
  };

  localparam byte_t UpperMap [MapSize] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85,
    8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D,
    8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
    8'h96, 8'h97, 8'h98, 8'h99, 8'h00, 8'h00, 8'h00, 8'h9A,
    8'h9B
  };

endpackage

### hdl/sc2a_decode.sv
// ----------------------------------------------------------------------------
// sc2a_decode
// Modifier flags and map lookup for one scan code per advancing cycle.
// ----------------------------------------------------------------------------
module sc2a_decode import sc2a_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  byte_t code,
  output byte_t char_code
);

  mods_t mods;
  mods_t mods_next;
  logic [MapIdxW-1:0] idx;
  logic  shifted;
  byte_t mapped;

  always_comb begin
    mods_next = mods;
    case (code)
      CodeLShiftMake:  mods_next.lshift = 1'b1;
      CodeRShiftMake:  mods_next.rshift = 1'b1;
      CodeLShiftBreak: mods_next.lshift = 1'b0;
      CodeRShiftBreak: mods_next.rshift = 1'b0;
      CodeCapsBreak:   mods_next.caps   = ~mods.caps;
      default:         mods_next        = mods;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mods <= '0;
    end else if (step) begin
      mods <= mods_next;
    end
  end

  assign idx     = code[MapIdxW-1:0];
  assign shifted = mods.lshift | mods.rshift | mods.caps;

  always_comb begin
    if (code == CodeBackspace) begin
      mapped = CharBackspace;
    end else if (code > CodeMapLast) begin
      mapped = CharNone;
    end else if (shifted) begin
      mapped = UpperMap[idx];
    end else begin
      mapped = LowerMap[idx];
    end
  end

  assign char_code = mapped;

endmodule

### hdl/scan_code_to_ascii_translator.sv
// ----------------------------------------------------------------------------
// scan_code_to_ascii_translator
// Set-1 scan code to character translator with shift and caps lock tracking.
// ----------------------------------------------------------------------------
//  channel   direction  tdata fields (low bit up)
//  s_axis    in         scan_code [7:0]
//  m_axis    out        char_code [7:0]
//
//  One request per cycle sustained while the result is not stalled.
//  An input register feeds the flag update and map lookup, which load the result register.
//  Reset clears both valid bits and all modifier flags.
//  A stalled result holds the result register; the input register still takes one more request if it is empty.
// ----------------------------------------------------------------------------
module scan_code_to_ascii_translator import sc2a_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] scan_code
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [7:0] char_code
);

  logic  in_valid;
  byte_t in_code;
  logic  out_valid;
  byte_t out_char;
  logic  advance;
  byte_t char_code;

  assign advance       = in_valid & (~out_valid | m_axis_tready);
  assign s_axis_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_code <= s_axis_tdata;
    end
  end

  sc2a_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .code      (in_code),
    .char_code (char_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char <= char_code;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_char;

endmodule

### hdl/sc2a_checker.sv
// ----------------------------------------------------------------------------
// sc2a_checker
// Port-level checks for the scan code translator, bound to the top level.
// ----------------------------------------------------------------------------
`include "scan_code_to_ascii_translator_defines.svh"

module sc2a_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  logic in_stall;
  logic out_stall;
  logic fkey_ok;

  assign in_stall  = s_axis_tvalid & ~s_axis_tready;
  assign out_stall = m_axis_tvalid & ~m_axis_tready;
  assign fkey_ok   = (m_axis_tdata >= 8'd129) && (m_axis_tdata <= 8'd155);

  `SC2A_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "result valid after reset")
  `SC2A_ASSERT(a_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "result not held")
  `SC2A_ASSERT(a_in_hold, in_stall |=> s_axis_tvalid && $stable(s_axis_tdata), "request not held")
  `SC2A_ASSERT(a_ready, !s_axis_tready |-> out_stall, "input stalled without output stall")
  `SC2A_ASSERT(a_char_range, m_axis_tvalid && m_axis_tdata[7] |-> fkey_ok, "code out of range")

endmodule

bind scan_code_to_ascii_translator sc2a_checker u_sc2a_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
